[sv/linear_frequency_sweep_unit_assert.svh]
// Assertion macros for the linear frequency sweep unit.
// Included by the top level; no other dependencies.
`ifndef LINEAR_FREQUENCY_SWEEP_UNIT_ASSERT_SVH
`define LINEAR_FREQUENCY_SWEEP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[sv/lfs_pkg.sv]
// Shared types and constants for the linear frequency sweep unit.
// No dependencies; used by lfs_divider and linear_frequency_sweep_unit.
package lfs_pkg;

   localparam int FREQ_W    = 29;
   localparam int TIME_W    = 32;
   localparam int PERIOD_W  = 16;
   localparam int ERR_W     = 25;
   localparam int PROD_W    = FREQ_W + PERIOD_W;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 3;
   localparam int SUM_W     = FREQ_W + 2;

   // Step counts of the shared divider: modulo pass and scaling pass.
   localparam logic [CNT_W-1:0] MOD_STEPS = CNT_W'(TIME_W);
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);

   localparam logic [TIME_W-1:0] HOLDOFF_MS = 32'd5;

   // Input word kinds.
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_ENABLE  = 2'd1;
   localparam logic [1:0] KIND_DISABLE = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_STOP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LO_ERROR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_MIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_MAX    = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MOD  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   // Command from the sequencer to the divider.
   typedef struct packed {
      logic                start;
      logic [CNT_W-1:0]    steps;
      logic [PROD_W-1:0]   dividend;
      logic [PERIOD_W-1:0] divisor;
   } div_cmd_type;

   // Status and results from the divider.
   typedef struct packed {
      logic                busy;
      logic                done;
      logic [PERIOD_W-1:0] rem;
      logic [PROD_W-1:0]   quo;
   } div_stat_type;

endpackage

[sv/lfs_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by the modulo and scaling passes.
// Depends on lfs_pkg.
module lfs_divider
   import lfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output div_stat_type stat
);

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W:0]   trial;

   // One trial subtraction on the partial remainder.
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         cnt_in = cmd.steps;
         rem_in = '0;
         quo_in = cmd.dividend;
         dvs_in = cmd.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!trial[PERIOD_W]) begin
            rem_in = trial[PERIOD_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[PERIOD_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign stat.rem  = rem_ff;
   assign stat.quo  = quo_ff;

endmodule

[sv/linear_frequency_sweep_unit.sv]
// Linear frequency sweep unit: a repeating sawtooth sweep of an oscillator frequency.
// An enable word goes to the finish state, a disable word is done in the idle state, and a tick word that
// comes while running and is not held off runs a 32-step modulo pass, a multiply state, a 45-step scaling
// divide and a finish state, both divides on the one-bit-per-cycle divider that both passes share.
// Input is not taken while a word is in work; a finished result waits in the output register while the
// next word is accepted, and the finish state stalls only if a new result meets a full register not being read.
// Depends on lfs_pkg, lfs_divider and linear_frequency_sweep_unit_assert.svh.
module linear_frequency_sweep_unit
   import lfs_pkg::*;
#(
   parameter int PERIOD_MIN_MS = 10,
   parameter int PERIOD_MAX_MS = 60000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [TIME_W-1:0]    req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [FREQ_W-1:0]    rsp_lo_freq_hz,
   output logic [FREQ_W-1:0]    rsp_sweep_freq_hz,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FREQ_W-1:0]    csr_data
);

   `include "linear_frequency_sweep_unit_assert.svh"

   localparam logic [PERIOD_W-1:0] P_MIN = PERIOD_W'(PERIOD_MIN_MS);
   localparam logic [PERIOD_W-1:0] P_MAX = PERIOD_W'(PERIOD_MAX_MS);

   // Configuration registers.
   logic [FREQ_W-1:0]   first_hz_ff, stop_hz_ff, band_min_ff, band_max_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [ERR_W-1:0]    lo_err_ff;

   // Sweep state.
   state_type         state_ff, state_in;
   logic              running_ff, running_in;
   logic [TIME_W-1:0] start_time_ff, start_time_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [FREQ_W-1:0] current_ff, current_in;
   logic [FREQ_W-1:0] next_ff, next_in;
   logic              force_ff, force_in;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [FREQ_W-1:0] out_lo_ff, out_lo_in;
   logic [FREQ_W-1:0] out_sweep_ff, out_sweep_in;

   div_cmd_type  div_cmd;
   div_stat_type div_stat;

   logic [FREQ_W-1:0]   a_clamp, b_clamp, range_lo, range_hi, span;
   logic [PERIOD_W-1:0] period_use;
   logic [TIME_W-1:0]   start_eff, last_eff, diff_now;
   logic                held_off, emit, slot_free, accept;
   logic signed [SUM_W-1:0] corr_sum, band_min_s, band_max_s;
   logic [FREQ_W-1:0]   corr_freq;

   // Start and stop frequencies clamped to the band and put in order.
   always_comb begin
      a_clamp = first_hz_ff;
      if (first_hz_ff < band_min_ff) begin
         a_clamp = band_min_ff;
      end else if (first_hz_ff > band_max_ff) begin
         a_clamp = band_max_ff;
      end
      b_clamp = stop_hz_ff;
      if (stop_hz_ff < band_min_ff) begin
         b_clamp = band_min_ff;
      end else if (stop_hz_ff > band_max_ff) begin
         b_clamp = band_max_ff;
      end
      if (a_clamp > b_clamp) begin
         range_lo = b_clamp;
         range_hi = a_clamp;
      end else begin
         range_lo = a_clamp;
         range_hi = b_clamp;
      end
      span = range_hi - range_lo;
   end

   // Period clamped to its bounds.
   always_comb begin
      period_use = period_ff;
      if (period_ff < P_MIN) begin
         period_use = P_MIN;
      end
      if (period_use > P_MAX) begin
         period_use = P_MAX;
      end
   end

   // Start time latch and tick hold-off.
   assign start_eff = (start_time_ff == '0) ? req_now_ms : start_time_ff;
   assign last_eff  = (start_time_ff == '0) ? '0 : last_time_ff;
   assign held_off  = (last_eff != '0) && ((req_now_ms - last_eff) < HOLDOFF_MS);
   assign diff_now  = req_now_ms - start_eff;

   // Error offset added and the sum saturated to the band.
   assign corr_sum   = $signed({2'b00, next_ff}) + SUM_W'($signed(lo_err_ff));
   assign band_min_s = $signed({2'b00, band_min_ff});
   assign band_max_s = $signed({2'b00, band_max_ff});
   always_comb begin
      corr_freq = next_ff + FREQ_W'($signed(lo_err_ff));
      if (corr_sum < band_min_s) begin
         corr_freq = band_min_ff;
      end else if (corr_sum > band_max_s) begin
         corr_freq = band_max_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !out_valid_ff || rsp_ready;
   assign emit      = force_ff || (next_ff != current_ff);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      start_time_in = start_time_ff;
      last_time_in  = last_time_ff;
      current_in    = current_ff;
      next_in       = next_ff;
      force_in      = force_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_lo_in     = out_lo_ff;
      out_sweep_in  = out_sweep_ff;
      div_cmd.start    = 1'b0;
      div_cmd.steps    = MOD_STEPS;
      div_cmd.dividend = {diff_now, {(PROD_W-TIME_W){1'b0}}};
      div_cmd.divisor  = period_use;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_ENABLE: begin
                     running_in    = 1'b1;
                     start_time_in = '0;
                     last_time_in  = '0;
                     next_in       = range_lo;
                     force_in      = 1'b1;
                     state_in      = ST_FIN;
                  end
                  KIND_DISABLE: begin
                     running_in = 1'b0;
                  end
                  KIND_TICK: begin
                     if (running_ff) begin
                        start_time_in = start_eff;
                        last_time_in  = last_eff;
                        if (!held_off) begin
                           last_time_in  = req_now_ms;
                           force_in      = 1'b0;
                           div_cmd.start = 1'b1;
                           state_in      = ST_MOD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (div_stat.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // Elapsed time within the period times the span, then divided by the period.
            div_cmd.start    = 1'b1;
            div_cmd.steps    = DIV_STEPS;
            div_cmd.dividend = PROD_W'(div_stat.rem * span);
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               next_in  = range_lo + div_stat.quo[FREQ_W-1:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!emit) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               current_in   = next_ff;
               out_valid_in = 1'b1;
               out_lo_in    = corr_freq;
               out_sweep_in = next_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         running_ff    <= 1'b0;
         start_time_ff <= '0;
         last_time_ff  <= '0;
         current_ff    <= '0;
         force_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         start_time_ff <= start_time_in;
         last_time_ff  <= last_time_in;
         current_ff    <= current_in;
         force_ff      <= force_in;
         out_valid_ff  <= out_valid_in;
      end
      next_ff      <= next_in;
      out_lo_ff    <= out_lo_in;
      out_sweep_ff <= out_sweep_in;
   end

   // Configuration writes.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         first_hz_ff <= FREQ_W'(1000000);
         stop_hz_ff  <= FREQ_W'(10000000);
         period_ff   <= PERIOD_W'(1000);
         lo_err_ff   <= '0;
         band_min_ff <= FREQ_W'(1000000);
         band_max_ff <= FREQ_W'(200000000);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SWEEP_START: first_hz_ff <= csr_data;
            REG_SWEEP_STOP:  stop_hz_ff  <= csr_data;
            REG_PERIOD:      period_ff   <= csr_data[PERIOD_W-1:0];
            REG_LO_ERROR:    lo_err_ff   <= csr_data[ERR_W-1:0];
            REG_BAND_MIN:    band_min_ff <= csr_data;
            REG_BAND_MAX:    band_max_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   lfs_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_lo_freq_hz    = out_lo_ff;
   assign rsp_sweep_freq_hz = out_sweep_ff;

   // A pending result always carries the frequency now held as current.
   `LFS_ASSERT_SAME(a_rsp_matches_current, clock, reset, rsp_valid,
      rsp_sweep_freq_hz == current_ff)
   // The divider is never restarted while it is still iterating.
   `LFS_ASSERT_SAME(a_div_start_idle, clock, reset, div_cmd.start, !div_stat.busy)
   // A divider result only arrives while the sequencer waits for it.
   `LFS_ASSERT_SAME(a_div_done_waited, clock, reset, div_stat.done,
      (state_ff == ST_MOD) || (state_ff == ST_DIV))
   // A tick that starts the modulo pass keeps the divider busy in the next cycle.
   `LFS_ASSERT_NEXT(a_mod_runs, clock, reset, (state_ff == ST_IDLE) && div_cmd.start,
      div_stat.busy && (state_ff == ST_MOD))

endmodule

[bench/tb_linear_frequency_sweep_unit.sv]
// Self-checking bench for linear_frequency_sweep_unit: predicts each frequency word and compares.
// Depends on lfs_pkg and the RTL of the sweep unit; no files or arguments are read.
module tb_linear_frequency_sweep_unit;
   import lfs_pkg::*;

   localparam int SWEEP_PERIOD_MIN = 10;
   localparam int SWEEP_PERIOD_MAX = 60000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 150;
   localparam int ERR_LIMIT = 10000000;

   typedef struct {
      logic [FREQ_W-1:0] lo_freq;
      logic [FREQ_W-1:0] sweep_freq;
   } freq_word_type;

   // Tracks the sweep state and holds the frequency words still owed by the block.
   class sweep_tracker;
      logic [FREQ_W-1:0]   first_hz, stop_hz, band_min, band_max;
      logic [PERIOD_W-1:0] period_cfg;
      logic [ERR_W-1:0]    lo_err;
      bit                  running;
      logic [TIME_W-1:0]   start_time, last_time;
      logic [FREQ_W-1:0]   freq_now;
      freq_word_type       pending_freqs[$];
      int                  errors;

      function new();
         first_hz   = 29'd1000000;
         stop_hz    = 29'd10000000;
         period_cfg = 16'd1000;
         lo_err     = '0;
         band_min   = 29'd1000000;
         band_max   = 29'd200000000;
         running    = 1'b0;
         start_time = '0;
         last_time  = '0;
         freq_now   = '0;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [FREQ_W-1:0] data);
         case (idx)
            REG_SWEEP_START: first_hz = data;
            REG_SWEEP_STOP:  stop_hz = data;
            REG_PERIOD:      period_cfg = data[PERIOD_W-1:0];
            REG_LO_ERROR:    lo_err = data[ERR_W-1:0];
            REG_BAND_MIN:    band_min = data;
            REG_BAND_MAX:    band_max = data;
            default: ;
         endcase
      endfunction

      // Inverted band: below the low bound gives the low bound, else the high bound.
      function logic [FREQ_W-1:0] clamp_band(logic [FREQ_W-1:0] f);
         if (f < band_min) return band_min;
         if (f > band_max) return band_max;
         return f;
      endfunction

      function int unsigned period_eff();
         int unsigned p;
         p = period_cfg;
         if (p < SWEEP_PERIOD_MIN) p = SWEEP_PERIOD_MIN;
         if (p > SWEEP_PERIOD_MAX) p = SWEEP_PERIOD_MAX;
         if (p == 0) p = 1;
         return p;
      endfunction

      function void sweep_bounds(output logic [FREQ_W-1:0] lo, output logic [FREQ_W-1:0] hi);
         logic [FREQ_W-1:0] a, b;
         a = clamp_band(first_hz);
         b = clamp_band(stop_hz);
         if (a > b) begin
            lo = b;
            hi = a;
         end else begin
            lo = a;
            hi = b;
         end
      endfunction

      // Adds the signed oscillator error and saturates the sum to the band.
      function logic [FREQ_W-1:0] with_error(logic [FREQ_W-1:0] f);
         longint err_val;
         longint sum;
         err_val = $signed(lo_err);
         sum = longint'(f) + err_val;
         if (sum < longint'(band_min)) return band_min;
         if (sum > longint'(band_max)) return band_max;
         return sum[FREQ_W-1:0];
      endfunction

      function void owe_current();
         freq_word_type w;
         w.lo_freq = with_error(freq_now);
         w.sweep_freq = freq_now;
         pending_freqs.push_back(w);
      endfunction

      // Applies one accepted word; returns 1 when the word can change the sweep.
      function bit take_word(logic [1:0] kind, logic [TIME_W-1:0] now_ms);
         logic [FREQ_W-1:0] lo, hi, next_freq;
         logic [TIME_W-1:0] per, elapsed;
         logic [63:0]       scaled;
         case (kind)
            KIND_ENABLE: begin
               sweep_bounds(lo, hi);
               running = 1'b1;
               start_time = '0;
               last_time = '0;
               freq_now = lo;
               owe_current();
               return 1'b1;
            end
            KIND_DISABLE: begin
               running = 1'b0;
               return 1'b1;
            end
            KIND_TICK: begin
               if (!running) return 1'b0;
               // A start time of zero means the sweep has not latched one yet.
               if (start_time == '0) begin
                  start_time = now_ms;
                  last_time = '0;
               end
               if (last_time != '0 && (now_ms - last_time) < HOLDOFF_MS) return 1'b1;
               last_time = now_ms;
               per = period_eff();
               elapsed = (now_ms - start_time) % per;
               sweep_bounds(lo, hi);
               scaled = (64'(elapsed) * 64'(hi - lo)) / 64'(per);
               next_freq = lo + scaled[FREQ_W-1:0];
               if (next_freq != freq_now) begin
                  freq_now = next_freq;
                  owe_current();
               end
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_freqs(logic [FREQ_W-1:0] lo_freq, logic [FREQ_W-1:0] sweep_freq);
         freq_word_type w;
         if (pending_freqs.size() == 0) begin
            report($sformatf("unexpected word lo %0d sweep %0d", lo_freq, sweep_freq));
         end else begin
            w = pending_freqs.pop_front();
            if (lo_freq !== w.lo_freq)
               report($sformatf("lo_freq_hz got %0d expected %0d", lo_freq, w.lo_freq));
            if (sweep_freq !== w.sweep_freq)
               report($sformatf("sweep_freq_hz got %0d expected %0d", sweep_freq,
                                w.sweep_freq));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_kind;
   logic [TIME_W-1:0]    req_now_ms;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [FREQ_W-1:0]    rsp_lo_freq_hz;
   logic [FREQ_W-1:0]    rsp_sweep_freq_hz;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FREQ_W-1:0]    csr_data;

   sweep_tracker tracker = new();
   bit calm = 1'b0;
   int live_words = 0;

   linear_frequency_sweep_unit #(
      .PERIOD_MIN_MS(SWEEP_PERIOD_MIN),
      .PERIOD_MAX_MS(SWEEP_PERIOD_MAX)
   ) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: not ready in about 30 percent of cycles except during a calm stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = calm || ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_freqs(rsp_lo_freq_hz, rsp_sweep_freq_hz);
   end

   // Sends one word, with a random gap in front of it unless the stretch is calm.
   task send_word(logic [1:0] kind, logic [TIME_W-1:0] now_ms);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 30)
         gap = ($urandom_range(9) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 8);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_kind = kind;
      req_now_ms = now_ms;
      do @(posedge clock); while (!req_ready);
      if (tracker.take_word(kind, now_ms)) live_words++;
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [FREQ_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task write_all(int unsigned first_hz, int unsigned stop_hz, int unsigned period,
                  int err_hz, int unsigned bmin, int unsigned bmax);
      logic [ERR_W-1:0] err_bits;
      err_bits = err_hz[ERR_W-1:0];
      write_csr(REG_BAND_MIN, bmin[FREQ_W-1:0]);
      write_csr(REG_BAND_MAX, bmax[FREQ_W-1:0]);
      write_csr(REG_SWEEP_START, first_hz[FREQ_W-1:0]);
      write_csr(REG_SWEEP_STOP, stop_hz[FREQ_W-1:0]);
      write_csr(REG_PERIOD, FREQ_W'(period[PERIOD_W-1:0]));
      write_csr(REG_LO_ERROR, FREQ_W'(err_bits));
      // Unused indexes must leave every register alone.
      if ($urandom_range(1) == 0)
         write_csr(REG_SPARE_LO, FREQ_W'($urandom_range(0, 500000000)));
      if ($urandom_range(1) == 0)
         write_csr(REG_SPARE_HI, FREQ_W'($urandom_range(0, 500000000)));
   endtask

   // Lets every owed word arrive, then waits out a tick that may still be in work.
   task settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending_freqs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly enable runs of ascending ticks, with noise words mixed in.
   task sweep_traffic(int target);
      int                first_count, run, pick;
      int unsigned       per;
      logic [TIME_W-1:0] now_ms;
      first_count = live_words;
      now_ms = $urandom;
      while (live_words - first_count < target) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            case ($urandom_range(3))
               0: now_ms = $urandom;
               1: now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
               2: now_ms = '0;
               default: ;
            endcase
            send_word(KIND_ENABLE, $urandom);
            run = $urandom_range(3, 14);
            per = tracker.period_eff();
            repeat (run) begin
               pick = $urandom_range(99);
               if (pick < 15) now_ms += $urandom_range(0, 4);
               else if (pick < 75) now_ms += $urandom_range(5, (per / 4) + 5);
               else if (pick < 95) now_ms += $urandom_range(5, 3 * per);
               else now_ms += $urandom;
               send_word(KIND_TICK, now_ms);
            end
            if ($urandom_range(3) == 0) send_word(KIND_DISABLE, $urandom);
         end else if (pick < 85) begin
            send_word(KIND_DISABLE, $urandom);
         end else if (pick < 93) begin
            send_word(KIND_TICK, $urandom);
         end else begin
            send_word(KIND_UNUSED, $urandom);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_TICK;
      req_now_ms = '0;
      csr_valid = 1'b0;
      csr_index = REG_SWEEP_START;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words on the reset settings.
      send_word(KIND_UNUSED, 32'hFFFF_FFFF);
      send_word(KIND_TICK, 32'd100);
      send_word(KIND_DISABLE, 32'd0);
      send_word(KIND_ENABLE, 32'd0);
      send_word(KIND_TICK, 32'd0);
      send_word(KIND_TICK, 32'd3);
      send_word(KIND_TICK, 32'd5);
      send_word(KIND_TICK, 32'd500);
      send_word(KIND_TICK, 32'd1502);
      send_word(KIND_TICK, 32'd1504);
      send_word(KIND_TICK, 32'hFFFF_FFFF);
      send_word(KIND_TICK, 32'h0000_0010);
      send_word(KIND_ENABLE, 32'hFFFF_FFFF);
      send_word(KIND_TICK, 32'hFFFF_FFF0);
      send_word(KIND_TICK, 32'hFFFF_FFF2);
      send_word(KIND_TICK, 32'h0000_0100);
      send_word(KIND_TICK, 32'h8000_0000);
      send_word(KIND_UNUSED, 32'd0);
      send_word(KIND_DISABLE, 32'hFFFF_FFFF);
      send_word(KIND_TICK, 32'h5555_5555);
      send_word(KIND_ENABLE, 32'hAAAA_AAAA);
      send_word(KIND_TICK, 32'hAAAA_AAAA);
      send_word(KIND_TICK, 32'hAAAA_ACAA);
      settle();

      // Phases of settings, extremes first, each followed by random traffic.
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: ;
            1: write_all(0, 500000000, 0, -ERR_LIMIT, 0, 500000000);
            2: write_all(500000000, 0, 65535, ERR_LIMIT, 1000000, 200000000);
            3: write_all($urandom_range(0, 500000000), $urandom_range(0, 500000000), 1,
                         $urandom_range(0, 2 * ERR_LIMIT) - ERR_LIMIT, 300000000, 100000000);
            4: write_all(12345678, 12345678, 10, 0, 0, 500000000);
            5: write_all(0, 500000000, 60000, -ERR_LIMIT, 5000000, 495000000);
            6: write_all($urandom_range(0, 500000000), $urandom_range(0, 500000000),
                         $urandom_range(9, 11), $urandom_range(0, 2 * ERR_LIMIT) - ERR_LIMIT,
                         $urandom_range(0, 50000000), $urandom_range(450000000, 500000000));
            default:
               write_all($urandom_range(0, 500000000), $urandom_range(0, 500000000),
                         $urandom_range(0, 65535), $urandom_range(0, 2 * ERR_LIMIT) - ERR_LIMIT,
                         $urandom_range(0, 250000000), $urandom_range(100000000, 500000000));
         endcase
         calm = (phase == 5);
         sweep_traffic(180);
         settle();
         calm = 1'b0;
      end

      if (tracker.pending_freqs.size() != 0)
         tracker.report($sformatf("%0d frequency words never arrived",
                                  tracker.pending_freqs.size()));
      if (tracker.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
